[src/pqm_pkg.sv]
// ----------------------------------------------------------------------------
// pqm_pkg
// Shared types and constants for the power quality meter.
// ----------------------------------------------------------------------------
package pqm_pkg;

    localparam int MAX_FRAME  = 1024;
    localparam int CNT_W      = $clog2(MAX_FRAME + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [3:0]  AVG_RESET = 4'd5;
    localparam logic [22:0] RMS_MAX   = 23'h7FFFFF;
    localparam logic [15:0] CREST_MAX = 16'hFFFF;
    localparam logic [16:0] PF_ONE    = 17'd32768;

    typedef struct packed {
        logic        [40:0] vsq;
        logic        [40:0] csq;
        logic signed [41:0] psum;
        logic [CNT_W-1:0]   n;
        logic signed [15:0] vmax;
        logic signed [15:0] vmin;
        logic signed [15:0] cmax;
        logic signed [15:0] cmin;
    } t_frame_rec;

    typedef enum logic {
        MOP_DIV,
        MOP_SQRT
    } t_math_op;

    typedef struct packed {
        logic        start;
        t_math_op    op;
        logic [63:0] a;
        logic [31:0] b;
    } t_math_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_math_rsp;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_VDIV,
        BK_VSQ,
        BK_CDIV,
        BK_CSQ,
        BK_PDIV,
        BK_CHK,
        BK_VAVG,
        BK_CAVG,
        BK_PAVG,
        BK_MUL,
        BK_SQR,
        BK_SUB,
        BK_REACT,
        BK_PF,
        BK_VCR,
        BK_CCR,
        BK_OUT
    } t_bk_state;

endpackage

[src/pqm_front.sv]
// ----------------------------------------------------------------------------
// pqm_front
// Sample front end: squares and products, per-frame sums and extremes.
// ----------------------------------------------------------------------------
module pqm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_voltage_sample,
    input  logic signed [15:0] i_current_sample,
    input  logic               i_last_in_frame,
    input  logic               i_fifo_full,
    output logic               o_push,
    output pqm_pkg::t_frame_rec o_rec
);
    import pqm_pkg::*;

    logic               r_a_valid;
    logic               r_a_last;
    logic signed [15:0] r_a_v;
    logic signed [15:0] r_a_c;
    logic signed [31:0] r_a_pv;
    logic signed [31:0] r_a_pc;
    logic signed [31:0] r_a_pp;

    logic        [40:0] r_vsq;
    logic        [40:0] r_csq;
    logic signed [41:0] r_psum;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [15:0] r_vmax, r_vmin, r_cmax, r_cmin;

    logic               a_end;
    logic               accept;
    logic               b_take;
    logic signed [15:0] b_vmax, b_vmin, b_cmax, b_cmin;
    logic signed [15:0] n_vmax, n_vmin, n_cmax, n_cmin;
    logic        [40:0] n_vsq, n_csq;
    logic signed [41:0] n_psum;
    logic [CNT_W-1:0]   n_cnt;

    assign a_end      = r_a_last || (r_cnt == CNT_W'(MAX_FRAME - 1));
    assign o_in_stall = r_a_valid && a_end && i_fifo_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign b_take     = r_a_valid && !o_in_stall;

    always_comb begin
        b_vmax = (r_cnt == '0) ? r_a_v : r_vmax;
        b_vmin = (r_cnt == '0) ? r_a_v : r_vmin;
        b_cmax = (r_cnt == '0) ? r_a_c : r_cmax;
        b_cmin = (r_cnt == '0) ? r_a_c : r_cmin;
        n_vmax = (r_a_v > b_vmax) ? r_a_v : b_vmax;
        n_vmin = (r_a_v < b_vmin) ? r_a_v : b_vmin;
        n_cmax = (r_a_c > b_cmax) ? r_a_c : b_cmax;
        n_cmin = (r_a_c < b_cmin) ? r_a_c : b_cmin;
        n_vsq  = r_vsq + {9'd0, r_a_pv};
        n_csq  = r_csq + {9'd0, r_a_pc};
        n_psum = r_psum + {{10{r_a_pp[31]}}, r_a_pp};
        n_cnt  = r_cnt + CNT_W'(1);
    end

    assign o_push      = b_take && a_end;
    assign o_rec.vsq   = n_vsq;
    assign o_rec.csq   = n_csq;
    assign o_rec.psum  = n_psum;
    assign o_rec.n     = n_cnt;
    assign o_rec.vmax  = n_vmax;
    assign o_rec.vmin  = n_vmin;
    assign o_rec.cmax  = n_cmax;
    assign o_rec.cmin  = n_cmin;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_v    <= i_voltage_sample;
            r_a_c    <= i_current_sample;
            r_a_last <= i_last_in_frame;
            r_a_pv   <= i_voltage_sample * i_voltage_sample;
            r_a_pc   <= i_current_sample * i_current_sample;
            r_a_pp   <= i_voltage_sample * i_current_sample;
        end
        if (b_take) begin
            r_vmax <= n_vmax;
            r_vmin <= n_vmin;
            r_cmax <= n_cmax;
            r_cmin <= n_cmin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_vsq     <= '0;
            r_csq     <= '0;
            r_psum    <= '0;
            r_cnt     <= '0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (b_take) begin
                r_a_valid <= 1'b0;
            end
            if (b_take) begin
                if (a_end) begin
                    r_vsq  <= '0;
                    r_csq  <= '0;
                    r_psum <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_vsq  <= n_vsq;
                    r_csq  <= n_csq;
                    r_psum <= n_psum;
                    r_cnt  <= n_cnt;
                end
            end
        end
    end

endmodule

[src/pqm_fifo.sv]
// ----------------------------------------------------------------------------
// pqm_fifo
// Short queue of completed frame records between front end and back end.
// ----------------------------------------------------------------------------
module pqm_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pqm_pkg::t_frame_rec i_rec,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output pqm_pkg::t_frame_rec o_rec
);
    import pqm_pkg::*;

    t_frame_rec         mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + (FIFO_AW + 1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/pqm_math.sv]
// ----------------------------------------------------------------------------
// pqm_math
// Shared iterative unit: 64/32 restoring divide or
// 64-bit integer square root.
// ----------------------------------------------------------------------------
module pqm_math (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pqm_pkg::t_math_req i_req,
    output pqm_pkg::t_math_rsp o_rsp
);
    import pqm_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_math_op    r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_acc;
    logic [31:0] r_div;
    logic [34:0] r_rem;
    logic [31:0] r_root;

    logic [32:0] d_sh, d_rem;
    logic        d_ge;
    logic [34:0] s_sh, s_trial, s_rem;
    logic        s_ge;
    logic [63:0] n_acc;
    logic [34:0] n_rem;
    logic [31:0] n_root;

    always_comb begin
        d_sh    = {r_rem[31:0], r_acc[63]};
        d_ge    = (d_sh >= {1'b0, r_div});
        d_rem   = d_ge ? (d_sh - {1'b0, r_div}) : d_sh;
        s_sh    = {r_rem[32:0], r_acc[63:62]};
        s_trial = {1'b0, r_root, 2'b01};
        s_ge    = (s_sh >= s_trial);
        s_rem   = s_ge ? (s_sh - s_trial) : s_sh;
        if (r_op == MOP_DIV) begin
            n_acc  = {r_acc[62:0], d_ge};
            n_rem  = {2'b00, d_rem};
            n_root = r_root;
        end else begin
            n_acc  = {r_acc[61:0], 2'b00};
            n_rem  = s_rem;
            n_root = {r_root[30:0], s_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = (r_op == MOP_DIV) ? r_acc : {32'd0, r_root};

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op   <= i_req.op;
            r_acc  <= i_req.a;
            r_div  <= i_req.b;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == MOP_DIV) ? 6'd63 : 6'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[src/pqm_back.sv]
// ----------------------------------------------------------------------------
// pqm_back
// Frame back end: frame RMS and mean power, averaging and report sequencing.
// ----------------------------------------------------------------------------
module pqm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_avg_frames,
    input  logic                i_fifo_empty,
    input  pqm_pkg::t_frame_rec i_rec,
    output logic                o_pop,
    output pqm_pkg::t_math_req  o_math_req,
    input  pqm_pkg::t_math_rsp  i_math_rsp,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [22:0]         o_volt_rms,
    output logic [22:0]         o_curr_rms,
    output logic signed [31:0]  o_real_power,
    output logic [30:0]         o_apparent_pwr,
    output logic [30:0]         o_reactive_pwr,
    output logic signed [16:0]  o_pf_value,
    output logic [15:0]         o_volt_crest,
    output logic [15:0]         o_curr_crest,
    output logic signed [15:0]  o_volt_max,
    output logic signed [15:0]  o_volt_min,
    output logic signed [15:0]  o_curr_max,
    output logic signed [15:0]  o_curr_min
);
    import pqm_pkg::*;

    t_bk_state   r_state, n_state;
    t_frame_rec  r_rec;
    logic        r_wait;
    logic [63:0] r_tmp;
    logic [27:0] r_vtot, r_ctot;
    logic [34:0] r_ptot;
    logic [3:0]  r_fd;
    logic [3:0]  r_k;
    logic [22:0] r_vr, r_cr;
    logic [31:0] r_real;
    logic [30:0] r_absr;
    logic [30:0] r_app;
    logic [61:0] r_app2, r_abs2, r_diff;
    logic [30:0] r_react;
    logic [16:0] r_pf;
    logic [15:0] r_vcr, r_ccr;
    logic        r_out_valid;

    logic        math_st;
    logic        skip;
    logic        adv;
    logic [3:0]  need, k_next;
    logic [41:0] psum_abs;
    logic [34:0] ptot_abs;
    logic [16:0] pk_v, pk_c;
    logic [22:0] rms_sat;
    logic [34:0] mean;
    logic [16:0] pfm;
    logic [15:0] crest_sat;
    logic [45:0] prod;

    function automatic logic [16:0] peak(input logic signed [15:0] mx,
                                         input logic signed [15:0] mn);
        logic [16:0] p, q;
        p = mx[15] ? 17'd0 : {1'b0, mx};
        q = mn[15] ? (17'd0 - {mn[15], mn}) : 17'd0;
        return (q > p) ? q : p;
    endfunction

    always_comb begin
        need      = (i_avg_frames == 4'd0) ? 4'd1 : i_avg_frames;
        k_next    = r_fd + 4'd1;
        psum_abs  = r_rec.psum[41] ? (42'd0 - r_rec.psum) : r_rec.psum;
        ptot_abs  = r_ptot[34] ? (35'd0 - r_ptot) : r_ptot;
        pk_v      = peak(r_rec.vmax, r_rec.vmin);
        pk_c      = peak(r_rec.cmax, r_rec.cmin);
        rms_sat   = (i_math_rsp.res > {41'd0, RMS_MAX}) ? RMS_MAX : i_math_rsp.res[22:0];
        mean      = {1'b0, i_math_rsp.res[33:0]};
        pfm       = (i_math_rsp.res > {47'd0, PF_ONE}) ? PF_ONE : i_math_rsp.res[16:0];
        crest_sat = (i_math_rsp.res > {48'd0, CREST_MAX}) ? CREST_MAX
                                                           : i_math_rsp.res[15:0];
        prod      = r_vr * r_cr;
    end

    // sequencer outputs: math requests, step advance and FIFO pop
    always_comb begin
        o_math_req.op = MOP_DIV;
        o_math_req.a  = '0;
        o_math_req.b  = '0;
        math_st       = 1'b1;
        skip          = 1'b0;
        unique case (r_state)
            BK_VDIV: begin
                o_math_req.a = {7'd0, r_rec.vsq, 16'd0};
                o_math_req.b = {{(32 - CNT_W){1'b0}}, r_rec.n};
            end
            BK_VSQ, BK_CSQ: begin
                o_math_req.op = MOP_SQRT;
                o_math_req.a  = r_tmp;
            end
            BK_CDIV: begin
                o_math_req.a = {7'd0, r_rec.csq, 16'd0};
                o_math_req.b = {{(32 - CNT_W){1'b0}}, r_rec.n};
            end
            BK_PDIV: begin
                o_math_req.a = {22'd0, psum_abs};
                o_math_req.b = {{(32 - CNT_W){1'b0}}, r_rec.n};
            end
            BK_VAVG: begin
                o_math_req.a = {36'd0, r_vtot};
                o_math_req.b = {28'd0, r_k};
            end
            BK_CAVG: begin
                o_math_req.a = {36'd0, r_ctot};
                o_math_req.b = {28'd0, r_k};
            end
            BK_PAVG: begin
                o_math_req.a = {29'd0, ptot_abs};
                o_math_req.b = {28'd0, r_k};
            end
            BK_REACT: begin
                o_math_req.op = MOP_SQRT;
                o_math_req.a  = {2'd0, r_diff};
                skip          = !(r_app > r_absr);
            end
            BK_PF: begin
                o_math_req.a = {18'd0, r_absr, 15'd0};
                o_math_req.b = {1'b0, r_app};
                skip         = (r_app == '0);
            end
            BK_VCR: begin
                o_math_req.a = {27'd0, pk_v, 20'd0};
                o_math_req.b = {9'd0, r_vr};
                skip         = (r_vr == '0);
            end
            BK_CCR: begin
                o_math_req.a = {27'd0, pk_c, 20'd0};
                o_math_req.b = {9'd0, r_cr};
                skip         = (r_cr == '0);
            end
            default: math_st = 1'b0;
        endcase
        o_math_req.start = math_st && !skip && !r_wait;
        if (math_st) begin
            adv = skip || (r_wait && i_math_rsp.done);
        end else if (r_state == BK_IDLE) begin
            adv = !i_fifo_empty;
        end else if (r_state == BK_OUT) begin
            adv = !r_out_valid;
        end else begin
            adv = 1'b1;
        end
        o_pop = (r_state == BK_IDLE) && !i_fifo_empty;
    end

    always_comb begin
        n_state = r_state;
        if (adv) begin
            unique case (r_state)
                BK_IDLE:  n_state = BK_VDIV;
                BK_VDIV:  n_state = BK_VSQ;
                BK_VSQ:   n_state = BK_CDIV;
                BK_CDIV:  n_state = BK_CSQ;
                BK_CSQ:   n_state = BK_PDIV;
                BK_PDIV:  n_state = BK_CHK;
                BK_CHK:   n_state = (k_next < need) ? BK_IDLE : BK_VAVG;
                BK_VAVG:  n_state = BK_CAVG;
                BK_CAVG:  n_state = BK_PAVG;
                BK_PAVG:  n_state = BK_MUL;
                BK_MUL:   n_state = BK_SQR;
                BK_SQR:   n_state = BK_SUB;
                BK_SUB:   n_state = BK_REACT;
                BK_REACT: n_state = BK_PF;
                BK_PF:    n_state = BK_VCR;
                BK_VCR:   n_state = BK_CCR;
                BK_CCR:   n_state = BK_OUT;
                BK_OUT:   n_state = BK_IDLE;
                default:  n_state = BK_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (r_state)
                BK_IDLE: r_rec <= i_rec;
                BK_VDIV, BK_CDIV: r_tmp <= i_math_rsp.res;
                BK_CHK: r_k <= k_next;
                BK_VAVG: r_vr <= i_math_rsp.res[22:0];
                BK_CAVG: r_cr <= i_math_rsp.res[22:0];
                BK_PAVG: begin
                    r_real  <= r_ptot[34] ? (32'd0 - i_math_rsp.res[31:0])
                                          : i_math_rsp.res[31:0];
                    r_absr  <= i_math_rsp.res[30:0];
                end
                BK_MUL: r_app <= {1'b0, prod[45:16]};
                BK_SQR: begin
                    r_app2 <= r_app * r_app;
                    r_abs2 <= r_absr * r_absr;
                end
                BK_SUB: r_diff <= r_app2 - r_abs2;
                BK_REACT: r_react <= skip ? 31'd0 : i_math_rsp.res[30:0];
                BK_PF: begin
                    if (skip) begin
                        r_pf <= '0;
                    end else begin
                        r_pf <= r_real[31] ? (17'd0 - pfm) : pfm;
                    end
                end
                BK_VCR: r_vcr <= skip ? 16'd0 : crest_sat;
                BK_CCR: r_ccr <= skip ? 16'd0 : crest_sat;
                BK_OUT: begin
                    o_volt_rms     <= r_vr;
                    o_curr_rms     <= r_cr;
                    o_real_power   <= r_real;
                    o_apparent_pwr <= r_app;
                    o_reactive_pwr <= r_react;
                    o_pf_value     <= r_pf;
                    o_volt_crest   <= r_vcr;
                    o_curr_crest   <= r_ccr;
                    o_volt_max     <= r_rec.vmax;
                    o_volt_min     <= r_rec.vmin;
                    o_curr_max     <= r_rec.cmax;
                    o_curr_min     <= r_rec.cmin;
                end
                default: r_tmp <= r_tmp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_wait      <= 1'b0;
            r_vtot      <= '0;
            r_ctot      <= '0;
            r_ptot      <= '0;
            r_fd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_math_req.start) begin
                r_wait <= 1'b1;
            end else if (i_math_rsp.done) begin
                r_wait <= 1'b0;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                case (r_state)
                    BK_VSQ:  r_vtot <= r_vtot + {5'd0, rms_sat};
                    BK_CSQ:  r_ctot <= r_ctot + {5'd0, rms_sat};
                    BK_PDIV: r_ptot <= r_ptot + (r_rec.psum[41] ? (35'd0 - mean) : mean);
                    BK_CHK: begin
                        if (k_next < need) begin
                            r_fd <= k_next;
                        end
                    end
                    BK_OUT: begin
                        r_out_valid <= 1'b1;
                        r_vtot      <= '0;
                        r_ctot      <= '0;
                        r_ptot      <= '0;
                        r_fd        <= '0;
                    end
                    default: r_fd <= r_fd;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/power_quality_meter_top.sv]
// ----------------------------------------------------------------------------
// power_quality_meter_top
// Single-phase RMS and power meter over framed voltage/current sample pairs.
//
//   channel   direction  handshake              payload
//   in        sink       i_in_valid/o_in_stall  voltage, current, last_in_frame
//   out       source     o_out_valid/i_out_stall  rms, powers, pf, crest, extremes
//   cfg       sink       i_cfg_we               i_cfg_wdata (avg_frames)
//
// Samples transfer one per cycle; o_in_stall rises only while the frame queue
// is full. The back end runs each frame, and each report, through the shared
// divide/root unit. Reset is synchronous, active low; no clearing pass.
// A stalled result holds in the output register while the next frame is processed.
// ----------------------------------------------------------------------------
module power_quality_meter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_voltage_sample,
    input  logic signed [15:0] i_current_sample,
    input  logic               i_last_in_frame,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [22:0]        o_volt_rms,
    output logic [22:0]        o_curr_rms,
    output logic signed [31:0] o_real_power,
    output logic [30:0]        o_apparent_pwr,
    output logic [30:0]        o_reactive_pwr,
    output logic signed [16:0] o_pf_value,
    output logic [15:0]        o_volt_crest,
    output logic [15:0]        o_curr_crest,
    output logic signed [15:0] o_volt_max,
    output logic signed [15:0] o_volt_min,
    output logic signed [15:0] o_curr_max,
    output logic signed [15:0] o_curr_min
);
    import pqm_pkg::*;

    logic       [3:0] r_avg_frames;
    logic             push, pop, fifo_full, fifo_empty;
    t_frame_rec       rec_in, rec_out;
    t_math_req        math_req;
    t_math_rsp        math_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_frames <= AVG_RESET;
        end else if (i_cfg_we) begin
            r_avg_frames <= i_cfg_wdata;
        end
    end

    pqm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_voltage_sample (i_voltage_sample),
        .i_current_sample (i_current_sample),
        .i_last_in_frame  (i_last_in_frame),
        .i_fifo_full      (fifo_full),
        .o_push           (push),
        .o_rec            (rec_in)
    );

    pqm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_rec   (rec_out)
    );

    pqm_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (math_req),
        .o_rsp   (math_rsp)
    );

    pqm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avg_frames   (r_avg_frames),
        .i_fifo_empty   (fifo_empty),
        .i_rec          (rec_out),
        .o_pop          (pop),
        .o_math_req     (math_req),
        .i_math_rsp     (math_rsp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_volt_rms     (o_volt_rms),
        .o_curr_rms     (o_curr_rms),
        .o_real_power   (o_real_power),
        .o_apparent_pwr (o_apparent_pwr),
        .o_reactive_pwr (o_reactive_pwr),
        .o_pf_value     (o_pf_value),
        .o_volt_crest   (o_volt_crest),
        .o_curr_crest   (o_curr_crest),
        .o_volt_max     (o_volt_max),
        .o_volt_min     (o_volt_min),
        .o_curr_max     (o_curr_max),
        .o_curr_min     (o_curr_min)
    );

endmodule

[src/pqm_checker.sv]
// ----------------------------------------------------------------------------
// pqm_checker
// Port-level checks on the meter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pqm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [30:0]        o_apparent_pwr,
    input logic [30:0]        o_reactive_pwr,
    input logic signed [16:0] o_pf_value,
    input logic signed [15:0] o_volt_max,
    input logic signed [15:0] o_volt_min,
    input logic signed [15:0] o_curr_max,
    input logic signed [15:0] o_curr_min
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pf_value <= 17'sd32768) && (o_pf_value >= -17'sd32768))
        else $error("power factor out of range");

    a_react: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_reactive_pwr <= o_apparent_pwr)
        else $error("reactive above apparent");

    a_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_volt_max >= o_volt_min) && (o_curr_max >= o_curr_min))
        else $error("frame extremes out of order");

endmodule

bind power_quality_meter_top pqm_checker u_pqm_checker (.*);
